[rtl/jdct_pkg.sv]
`default_nettype none

package jdct_pkg;

  localparam int SLOT_COUNT  = 4096;
  localparam int READY_DEPTH = 256;
  localparam int ID_W        = $clog2(SLOT_COUNT);
  localparam int TOP_W       = ID_W + 1;
  localparam int READY_W     = $clog2(READY_DEPTH);
  localparam int RTOP_W      = READY_W + 1;

  localparam logic [31:0] NO_HANDLE = 32'hFFFF_FFFF;
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_RUN     = 2'd0,
    REQ_TRIGGER = 2'd1,
    REQ_TAKE    = 2'd2,
    REQ_QUERY   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_RDY_FULL = 2'd2,
    ST_RDY_EMPT = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_RUN_FH,
    S_RUN_PRE,
    S_RUN_CHK,
    S_RUN_ALW,
    S_RUN_PR,
    S_RUN_PD,
    S_CH_PK,
    S_CH_RD,
    S_CH_PR,
    S_CH_PD,
    S_CH_PW,
    S_TRG_RD,
    S_TRG_CHK,
    S_WALK_RD,
    S_WALK_WR,
    S_TAKE_RD,
    S_QRY_RD,
    S_QRY_CHK
  } state_t;

  typedef struct packed {
    logic [15:0] gen;
    logic [15:0] cnt;
    logic        pv;
    logic [31:0] link;
    logic [31:0] tag;
    logic [31:0] fin;
  } slot_t;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic            peek;
    logic [ID_W-1:0] push_id;
  } fs_req_t;

  typedef struct packed {
    logic [TOP_W-1:0] top;
    logic [ID_W-1:0]  peek_id;
    logic             ready;
  } fs_stat_t;

  function automatic logic in_pool(input logic [31:0] h);
    return (h != NO_HANDLE) && ({1'b0, h[15:0]} < 17'(SLOT_COUNT));
  endfunction

  function automatic logic [ID_W-1:0] slot_idx(input logic [31:0] h);
    return h[ID_W-1:0];
  endfunction

  function automatic logic gen_ok(input logic [31:0] h, input slot_t w);
    return w.gen == h[31:16];
  endfunction

  function automatic logic [31:0] make_handle(input logic [15:0] g,
                                              input logic [ID_W-1:0] id);
    return {g, 16'(id)};
  endfunction

endpackage

`default_nettype wire

[rtl/jdct_free_stack.sv]
`default_nettype none

module jdct_free_stack (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire jdct_pkg::fs_req_t req,
  output jdct_pkg::fs_stat_t    stat
);

  logic [jdct_pkg::ID_W-1:0]  mem [jdct_pkg::SLOT_COUNT];
  logic [jdct_pkg::TOP_W-1:0] top_r;
  logic [jdct_pkg::TOP_W-1:0] top_nxt;
  logic [jdct_pkg::TOP_W-1:0] idx_r;
  logic [jdct_pkg::TOP_W-1:0] top_dec;
  logic [jdct_pkg::ID_W-1:0]  peek_q;
  logic                       init_w;

  assign init_w  = idx_r < jdct_pkg::TOP_W'(jdct_pkg::SLOT_COUNT);
  assign top_dec = top_r - jdct_pkg::TOP_W'(1);

  always_comb begin
    top_nxt = top_r;
    if (req.pop && top_r != '0) begin
      top_nxt = top_dec;
    end else if (req.push && top_r < jdct_pkg::TOP_W'(jdct_pkg::SLOT_COUNT)) begin
      top_nxt = top_r + jdct_pkg::TOP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= jdct_pkg::TOP_W'(jdct_pkg::SLOT_COUNT);
      idx_r <= '0;
    end else begin
      top_r <= top_nxt;
      if (init_w) begin
        idx_r <= idx_r + jdct_pkg::TOP_W'(1);
      end
    end
  end

  // fill each entry with its own slot id after reset, then serve the stack
  always_ff @(posedge clk) begin
    if (init_w) begin
      mem[idx_r[jdct_pkg::ID_W-1:0]] <= idx_r[jdct_pkg::ID_W-1:0];
    end else if (req.push && top_r < jdct_pkg::TOP_W'(jdct_pkg::SLOT_COUNT)) begin
      mem[top_r[jdct_pkg::ID_W-1:0]] <= req.push_id;
    end
    if (req.peek) begin
      peek_q <= mem[top_dec[jdct_pkg::ID_W-1:0]];
    end
  end

  assign stat.top     = top_r;
  assign stat.peek_id = peek_q;
  assign stat.ready   = !init_w;

endmodule

`default_nettype wire

[rtl/job_dependency_counter_table_top.sv]
`default_nettype none

// Channel   | Handshake                | Ports
// ----------+--------------------------+------------------------------------------
// request   | start high, busy low     | in_req_type, in_job_tag,
//           |                          | in_precondition_handle, in_want_finish,
//           |                          | in_finish_handle, in_target_handle
// result    | out_valid, one cycle     | out_status, out_resp_handle, out_out_job_tag,
//           |                          | out_out_job_finish, out_is_zero,
//           |                          | out_released_any
//
// One result per request. After reset the block holds busy while it clears the slot
// table and refills the free-slot stack, one entry a cycle.
// Reset is synchronous, active low. The receiver cannot stall: each result shows
// for one cycle and busy drops in that same cycle.

module job_dependency_counter_table_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_job_tag,
  input  wire logic [31:0] in_precondition_handle,
  input  wire logic        in_want_finish,
  input  wire logic [31:0] in_finish_handle,
  input  wire logic [31:0] in_target_handle,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_resp_handle,
  output logic [31:0]      out_out_job_tag,
  output logic [31:0]      out_out_job_finish,
  output logic             out_is_zero,
  output logic             out_released_any
);

  // slot table and ready store
  jdct_pkg::slot_t slot_mem [jdct_pkg::SLOT_COUNT];
  logic [63:0]     rdy_mem  [jdct_pkg::READY_DEPTH];

  jdct_pkg::slot_t             slot_q;
  logic                        slot_rd_en;
  logic [jdct_pkg::ID_W-1:0]   slot_rd_addr;
  logic                        slot_wr_en;
  logic [jdct_pkg::ID_W-1:0]   slot_wr_addr;
  jdct_pkg::slot_t             slot_wr_data;

  logic [63:0]                 rdy_q;
  logic                        rdy_rd_en;
  logic                        rdy_wr_en;
  logic [63:0]                 rdy_wr_data;

  jdct_pkg::fs_req_t  fs_req;
  jdct_pkg::fs_stat_t fs_stat;

  // sequencer registers
  jdct_pkg::state_t              state_r, state_nxt;
  logic [31:0]                   tag_r, tag_nxt;
  logic [31:0]                   pre_r, pre_nxt;
  logic                          want_r, want_nxt;
  logic [31:0]                   fh_r, fh_nxt;
  logic [31:0]                   tgt_r, tgt_nxt;
  logic                          reuse_r, reuse_nxt;
  logic                          zero_r, zero_nxt;
  logic [jdct_pkg::ID_W-1:0]     fslot_r, fslot_nxt;
  logic [jdct_pkg::ID_W-1:0]     chid_r, chid_nxt;
  logic [31:0]                   dec_r, dec_nxt;
  jdct_pkg::slot_t               fhw_r, fhw_nxt;
  jdct_pkg::slot_t               chw_r, chw_nxt;
  jdct_pkg::slot_t               pw_r, pw_nxt;
  logic [31:0]                   iter_r, iter_nxt;
  logic [jdct_pkg::TOP_W-1:0]    steps_r, steps_nxt;
  jdct_pkg::status_t             wst_r, wst_nxt;
  logic                          rel_r, rel_nxt;
  logic [jdct_pkg::TOP_W-1:0]    clr_r, clr_nxt;
  logic [jdct_pkg::RTOP_W-1:0]   rtop_r, rtop_nxt;
  logic [jdct_pkg::RTOP_W-1:0]   rtop_dec;

  logic                          out_valid_r, out_valid_nxt;
  jdct_pkg::status_t             ost_r, ost_nxt;
  logic [31:0]                   oresp_r, oresp_nxt;
  logic [31:0]                   otag_r, otag_nxt;
  logic [31:0]                   ofin_r, ofin_nxt;
  logic                          oisz_r, oisz_nxt;
  logic                          orel_r, orel_nxt;

  assign rtop_dec = rtop_r - jdct_pkg::RTOP_W'(1);

  jdct_free_stack u_free_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fs_req),
    .stat  (fs_stat)
  );

  always_comb begin
    jdct_pkg::slot_t   w;
    logic              alloc;
    logic              z;
    logic              pa;
    logic [1:0]        need;
    logic              fin_en;
    jdct_pkg::status_t r_st;
    logic [31:0]       r_resp;
    logic [31:0]       r_tag;
    logic [31:0]       r_fin;
    logic              r_isz;
    logic              r_rel;

    w      = slot_q;
    alloc  = want_r && !reuse_r;
    z      = 1'b0;
    pa     = 1'b0;
    need   = '0;
    fin_en = 1'b0;
    r_st   = jdct_pkg::ST_OK;
    r_resp = jdct_pkg::NO_HANDLE;
    r_tag  = '0;
    r_fin  = jdct_pkg::NO_HANDLE;
    r_isz  = 1'b0;
    r_rel  = 1'b0;

    state_nxt  = state_r;
    tag_nxt    = tag_r;
    pre_nxt    = pre_r;
    want_nxt   = want_r;
    fh_nxt     = fh_r;
    tgt_nxt    = tgt_r;
    reuse_nxt  = reuse_r;
    zero_nxt   = zero_r;
    fslot_nxt  = fslot_r;
    chid_nxt   = chid_r;
    dec_nxt    = dec_r;
    fhw_nxt    = fhw_r;
    chw_nxt    = chw_r;
    pw_nxt     = pw_r;
    iter_nxt   = iter_r;
    steps_nxt  = steps_r;
    wst_nxt    = wst_r;
    rel_nxt    = rel_r;
    clr_nxt    = clr_r;
    rtop_nxt   = rtop_r;

    out_valid_nxt = 1'b0;
    ost_nxt       = ost_r;
    oresp_nxt     = oresp_r;
    otag_nxt      = otag_r;
    ofin_nxt      = ofin_r;
    oisz_nxt      = oisz_r;
    orel_nxt      = orel_r;

    slot_rd_en   = 1'b0;
    slot_rd_addr = '0;
    slot_wr_en   = 1'b0;
    slot_wr_addr = '0;
    slot_wr_data = slot_q;
    rdy_rd_en    = 1'b0;
    rdy_wr_en    = 1'b0;
    rdy_wr_data  = '0;
    fs_req       = '0;

    case (state_r)
      jdct_pkg::S_INIT: begin
        if (clr_r < jdct_pkg::TOP_W'(jdct_pkg::SLOT_COUNT)) begin
          slot_wr_en   = 1'b1;
          slot_wr_addr = clr_r[jdct_pkg::ID_W-1:0];
          slot_wr_data = '{gen: '0, cnt: '0, pv: 1'b0, link: jdct_pkg::NO_HANDLE,
                           tag: '0, fin: '0};
          clr_nxt      = clr_r + jdct_pkg::TOP_W'(1);
        end else if (fs_stat.ready) begin
          state_nxt = jdct_pkg::S_IDLE;
        end
      end

      jdct_pkg::S_IDLE: begin
        if (start) begin
          tag_nxt   = in_job_tag;
          pre_nxt   = in_precondition_handle;
          want_nxt  = in_want_finish;
          fh_nxt    = in_finish_handle;
          tgt_nxt   = in_target_handle;
          case (jdct_pkg::req_t'(in_req_type))
            jdct_pkg::REQ_RUN:     state_nxt = jdct_pkg::S_RUN_FH;
            jdct_pkg::REQ_TRIGGER: state_nxt = jdct_pkg::S_TRG_RD;
            jdct_pkg::REQ_TAKE: begin
              if (rtop_r == '0) begin
                fin_en = 1'b1;
                r_st   = jdct_pkg::ST_RDY_EMPT;
              end else begin
                rdy_rd_en = 1'b1;
                rtop_nxt  = rtop_dec;
                state_nxt = jdct_pkg::S_TAKE_RD;
              end
            end
            jdct_pkg::REQ_QUERY:   state_nxt = jdct_pkg::S_QRY_RD;
            default:               state_nxt = jdct_pkg::S_IDLE;
          endcase
        end
      end

      // run: fetch finish slot, precondition slot and the free-stack top
      jdct_pkg::S_RUN_FH: begin
        slot_rd_en   = 1'b1;
        slot_rd_addr = jdct_pkg::slot_idx(fh_r);
        fs_req.peek  = 1'b1;
        state_nxt    = jdct_pkg::S_RUN_PRE;
      end

      jdct_pkg::S_RUN_PRE: begin
        fhw_nxt      = slot_q;
        reuse_nxt    = want_r && jdct_pkg::in_pool(fh_r) && jdct_pkg::gen_ok(fh_r, slot_q)
                       && slot_q.cnt != '0;
        fslot_nxt    = fs_stat.peek_id;
        slot_rd_en   = 1'b1;
        slot_rd_addr = jdct_pkg::slot_idx(pre_r);
        state_nxt    = jdct_pkg::S_RUN_CHK;
      end

      jdct_pkg::S_RUN_CHK: begin
        if (!jdct_pkg::in_pool(pre_r)) begin
          z = 1'b1;
        end else if (alloc && jdct_pkg::slot_idx(pre_r) == fslot_r) begin
          z = !jdct_pkg::gen_ok(pre_r, slot_q);
        end else begin
          z  = !jdct_pkg::gen_ok(pre_r, slot_q) || slot_q.cnt == '0;
          pa = slot_q.pv;
        end
        need = {1'b0, alloc} + {1'b0, !z && pa};
        if ((alloc && fs_stat.top == '0) || fs_stat.top < jdct_pkg::TOP_W'(need)) begin
          fin_en = 1'b1;
          r_st   = jdct_pkg::ST_NO_FREE;
        end else if (z && rtop_r >= jdct_pkg::RTOP_W'(jdct_pkg::READY_DEPTH)) begin
          fin_en = 1'b1;
          r_st   = jdct_pkg::ST_RDY_FULL;
        end else begin
          zero_nxt = z;
          if (reuse_r) begin
            w            = fhw_r;
            w.cnt        = (fhw_r.cnt == jdct_pkg::CNT_MAX) ? fhw_r.cnt
                                                            : fhw_r.cnt + 16'd1;
            slot_wr_en   = 1'b1;
            slot_wr_addr = jdct_pkg::slot_idx(fh_r);
            slot_wr_data = w;
            dec_nxt      = fh_r;
            state_nxt    = jdct_pkg::S_RUN_PR;
          end else if (alloc) begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = fslot_r;
            state_nxt    = jdct_pkg::S_RUN_ALW;
          end else begin
            dec_nxt   = jdct_pkg::NO_HANDLE;
            state_nxt = jdct_pkg::S_RUN_PR;
          end
        end
      end

      // take the fresh completion slot off the free stack
      jdct_pkg::S_RUN_ALW: begin
        w            = slot_q;
        w.cnt        = 16'd1;
        w.pv         = 1'b0;
        w.link       = jdct_pkg::NO_HANDLE;
        slot_wr_en   = 1'b1;
        slot_wr_addr = fslot_r;
        slot_wr_data = w;
        fs_req.pop   = 1'b1;
        dec_nxt      = jdct_pkg::make_handle(slot_q.gen, fslot_r);
        state_nxt    = jdct_pkg::S_RUN_PR;
      end

      jdct_pkg::S_RUN_PR: begin
        if (zero_r) begin
          rdy_wr_en   = 1'b1;
          rdy_wr_data = {tag_r, dec_r};
          rtop_nxt    = rtop_r + jdct_pkg::RTOP_W'(1);
          fin_en      = 1'b1;
          r_resp      = dec_r;
        end else begin
          slot_rd_en   = 1'b1;
          slot_rd_addr = jdct_pkg::slot_idx(pre_r);
          state_nxt    = jdct_pkg::S_RUN_PD;
        end
      end

      jdct_pkg::S_RUN_PD: begin
        if (slot_q.pv) begin
          fs_req.peek = 1'b1;
          state_nxt   = jdct_pkg::S_CH_PK;
        end else begin
          w            = slot_q;
          w.pv         = 1'b1;
          w.tag        = tag_r;
          w.fin        = dec_r;
          slot_wr_en   = 1'b1;
          slot_wr_addr = jdct_pkg::slot_idx(pre_r);
          slot_wr_data = w;
          fin_en       = 1'b1;
          r_resp       = dec_r;
        end
      end

      // chain the waiter through a new sibling slot
      jdct_pkg::S_CH_PK: begin
        chid_nxt     = fs_stat.peek_id;
        slot_rd_en   = 1'b1;
        slot_rd_addr = fs_stat.peek_id;
        state_nxt    = jdct_pkg::S_CH_RD;
      end

      jdct_pkg::S_CH_RD: begin
        w            = '{gen: slot_q.gen, cnt: 16'd1, pv: 1'b1, link: jdct_pkg::NO_HANDLE,
                         tag: tag_r, fin: dec_r};
        slot_wr_en   = 1'b1;
        slot_wr_addr = chid_r;
        slot_wr_data = w;
        chw_nxt      = w;
        fs_req.pop   = 1'b1;
        state_nxt    = jdct_pkg::S_CH_PR;
      end

      jdct_pkg::S_CH_PR: begin
        slot_rd_en   = 1'b1;
        slot_rd_addr = jdct_pkg::slot_idx(pre_r);
        state_nxt    = jdct_pkg::S_CH_PD;
      end

      jdct_pkg::S_CH_PD: begin
        pw_nxt       = slot_q;
        w            = chw_r;
        w.link       = slot_q.link;
        chw_nxt      = w;
        slot_wr_en   = 1'b1;
        slot_wr_addr = chid_r;
        slot_wr_data = w;
        state_nxt    = jdct_pkg::S_CH_PW;
      end

      jdct_pkg::S_CH_PW: begin
        w            = (chid_r == jdct_pkg::slot_idx(pre_r)) ? chw_r : pw_r;
        w.link       = jdct_pkg::make_handle(chw_r.gen, chid_r);
        slot_wr_en   = 1'b1;
        slot_wr_addr = jdct_pkg::slot_idx(pre_r);
        slot_wr_data = w;
        fin_en       = 1'b1;
        r_resp       = dec_r;
      end

      // trigger: decrement, and at zero walk the sibling chain
      jdct_pkg::S_TRG_RD: begin
        slot_rd_en   = 1'b1;
        slot_rd_addr = jdct_pkg::slot_idx(tgt_r);
        state_nxt    = jdct_pkg::S_TRG_CHK;
      end

      jdct_pkg::S_TRG_CHK: begin
        if (!(jdct_pkg::in_pool(tgt_r) && jdct_pkg::gen_ok(tgt_r, slot_q)
              && slot_q.cnt != '0)) begin
          fin_en = 1'b1;
        end else if (slot_q.cnt != 16'd1) begin
          w            = slot_q;
          w.cnt        = slot_q.cnt - 16'd1;
          slot_wr_en   = 1'b1;
          slot_wr_addr = jdct_pkg::slot_idx(tgt_r);
          slot_wr_data = w;
          fin_en       = 1'b1;
        end else begin
          iter_nxt  = tgt_r;
          steps_nxt = '0;
          wst_nxt   = jdct_pkg::ST_OK;
          rel_nxt   = 1'b0;
          state_nxt = jdct_pkg::S_WALK_RD;
        end
      end

      jdct_pkg::S_WALK_RD: begin
        if (steps_r < jdct_pkg::TOP_W'(jdct_pkg::SLOT_COUNT) && jdct_pkg::in_pool(iter_r))
        begin
          slot_rd_en   = 1'b1;
          slot_rd_addr = jdct_pkg::slot_idx(iter_r);
          state_nxt    = jdct_pkg::S_WALK_WR;
        end else begin
          fin_en = 1'b1;
          r_st   = wst_r;
          r_rel  = rel_r;
        end
      end

      jdct_pkg::S_WALK_WR: begin
        if (slot_q.pv) begin
          if (rtop_r < jdct_pkg::RTOP_W'(jdct_pkg::READY_DEPTH)) begin
            rdy_wr_en   = 1'b1;
            rdy_wr_data = {slot_q.tag, slot_q.fin};
            rtop_nxt    = rtop_r + jdct_pkg::RTOP_W'(1);
            rel_nxt     = 1'b1;
          end else begin
            wst_nxt = jdct_pkg::ST_RDY_FULL;
          end
        end
        w              = slot_q;
        w.gen          = slot_q.gen + 16'd1;
        w.cnt          = '0;
        w.pv           = 1'b0;
        w.link         = jdct_pkg::NO_HANDLE;
        slot_wr_en     = 1'b1;
        slot_wr_addr   = jdct_pkg::slot_idx(iter_r);
        slot_wr_data   = w;
        fs_req.push    = 1'b1;
        fs_req.push_id = jdct_pkg::slot_idx(iter_r);
        iter_nxt       = slot_q.link;
        steps_nxt      = steps_r + jdct_pkg::TOP_W'(1);
        state_nxt      = jdct_pkg::S_WALK_RD;
      end

      jdct_pkg::S_TAKE_RD: begin
        fin_en = 1'b1;
        r_tag  = rdy_q[63:32];
        r_fin  = rdy_q[31:0];
      end

      jdct_pkg::S_QRY_RD: begin
        slot_rd_en   = 1'b1;
        slot_rd_addr = jdct_pkg::slot_idx(tgt_r);
        state_nxt    = jdct_pkg::S_QRY_CHK;
      end

      jdct_pkg::S_QRY_CHK: begin
        fin_en = 1'b1;
        r_isz  = !(jdct_pkg::in_pool(tgt_r) && jdct_pkg::gen_ok(tgt_r, slot_q)
                   && slot_q.cnt != '0);
      end

      default: state_nxt = jdct_pkg::S_IDLE;
    endcase

    // drop the result into the output register and return to idle
    if (fin_en) begin
      out_valid_nxt = 1'b1;
      ost_nxt       = r_st;
      oresp_nxt     = r_resp;
      otag_nxt      = r_tag;
      ofin_nxt      = r_fin;
      oisz_nxt      = r_isz;
      orel_nxt      = r_rel;
      state_nxt     = jdct_pkg::S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jdct_pkg::S_INIT;
      clr_r       <= '0;
      rtop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rtop_r      <= rtop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    pre_r   <= pre_nxt;
    want_r  <= want_nxt;
    fh_r    <= fh_nxt;
    tgt_r   <= tgt_nxt;
    reuse_r <= reuse_nxt;
    zero_r  <= zero_nxt;
    fslot_r <= fslot_nxt;
    chid_r  <= chid_nxt;
    dec_r   <= dec_nxt;
    fhw_r   <= fhw_nxt;
    chw_r   <= chw_nxt;
    pw_r    <= pw_nxt;
    iter_r  <= iter_nxt;
    steps_r <= steps_nxt;
    wst_r   <= wst_nxt;
    rel_r   <= rel_nxt;
    ost_r   <= ost_nxt;
    oresp_r <= oresp_nxt;
    otag_r  <= otag_nxt;
    ofin_r  <= ofin_nxt;
    oisz_r  <= oisz_nxt;
    orel_r  <= orel_nxt;
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (slot_wr_en) begin
      slot_mem[slot_wr_addr] <= slot_wr_data;
    end
    if (slot_rd_en) begin
      slot_q <= slot_mem[slot_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_wr_en) begin
      rdy_mem[rtop_r[jdct_pkg::READY_W-1:0]] <= rdy_wr_data;
    end
    if (rdy_rd_en) begin
      rdy_q <= rdy_mem[rtop_dec[jdct_pkg::READY_W-1:0]];
    end
  end

  assign busy               = state_r != jdct_pkg::S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = ost_r;
  assign out_resp_handle    = oresp_r;
  assign out_out_job_tag    = otag_r;
  assign out_out_job_finish = ofin_r;
  assign out_is_zero        = oisz_r;
  assign out_released_any   = orel_r;

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while sequencer busy");

  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid) else $error("accepted request lost");

  a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rtop_r <= jdct_pkg::RTOP_W'(jdct_pkg::READY_DEPTH)) else $error("ready store overrun");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fs_stat.top <= jdct_pkg::TOP_W'(jdct_pkg::SLOT_COUNT)) else $error("free stack overrun");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fs_req.pop |-> fs_stat.top != '0) else $error("pop from empty free stack");

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jdct_pkg::*;

  localparam int N_RANDOM  = 420;
  localparam int WD_LIMIT  = 40000;  // covers the clearing pass and a full chain walk

  // Mirror of the counter table: counters, generations, parked jobs, chains, free stack.
  class dep_table_scoreboard;
    logic [15:0] cnt [SLOT_COUNT];
    logic [15:0] gen [SLOT_COUNT];
    bit          pv  [SLOT_COUNT];
    logic [31:0] ptag [SLOT_COUNT];
    logic [31:0] pfin [SLOT_COUNT];
    logic [31:0] link [SLOT_COUNT];
    int unsigned fstk [SLOT_COUNT];
    int unsigned ftop;
    logic [31:0] rtag [READY_DEPTH];
    logic [31:0] rfin [READY_DEPTH];
    int unsigned rtop;
    // expected result fields, oldest first
    logic [1:0]  q_st [$];
    logic [31:0] q_resp [$];
    logic [31:0] q_tag [$];
    logic [31:0] q_fin [$];
    bit          q_z [$];
    bit          q_rel [$];
    int          errors;
    logic [31:0] live_handles [$];

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cnt[i] = 0; gen[i] = 0; pv[i] = 0; link[i] = NO_HANDLE; fstk[i] = i;
      end
      ftop = SLOT_COUNT; rtop = 0; errors = 0;
    endfunction

    function bit pooled(logic [31:0] h);
      return h != NO_HANDLE && h[15:0] < SLOT_COUNT;
    endfunction

    function bit gen_match(logic [31:0] h);
      return gen[h[15:0]] == h[31:16];
    endfunction

    function bit is_live(logic [31:0] h);
      return pooled(h) && gen_match(h) && cnt[h[15:0]] != 0;
    endfunction

    function logic [31:0] grab_slot();
      int unsigned id;
      ftop--;
      id = fstk[ftop] % SLOT_COUNT;
      cnt[id] = 1; link[id] = NO_HANDLE; pv[id] = 0;
      live_handles.push_back({gen[id], 16'(id)});
      return {gen[id], 16'(id)};
    endfunction

    function bit ready_push(logic [31:0] t, logic [31:0] f);
      if (rtop >= READY_DEPTH) return 0;
      rtag[rtop] = t; rfin[rtop] = f; rtop++;
      return 1;
    endfunction

    function logic [1:0] run_job(logic [31:0] t, logic [31:0] pre, bit want,
                                 logic [31:0] fh, output logic [31:0] resp);
      bit reuse, alloc, zero, parked_after;
      int unsigned fslot, pid, need;
      logic [31:0] dec, ch;
      int unsigned cid;
      reuse = want && is_live(fh);
      alloc = want && !reuse;
      fslot = SLOT_COUNT; pid = 0; dec = NO_HANDLE; parked_after = 0;
      resp = NO_HANDLE;
      if (alloc) begin
        if (ftop == 0) return ST_NO_FREE;
        fslot = fstk[ftop-1] % SLOT_COUNT;
      end
      if (!pooled(pre)) zero = 1;
      else begin
        pid = pre[15:0];
        if (alloc && pid == fslot) zero = !gen_match(pre);
        else begin
          zero = !gen_match(pre) || cnt[pid] == 0;
          parked_after = pv[pid];
        end
      end
      need = (alloc ? 1 : 0) + ((!zero && parked_after) ? 1 : 0);
      if (ftop < need) return ST_NO_FREE;
      if (zero && rtop >= READY_DEPTH) return ST_RDY_FULL;
      if (reuse) begin
        if (cnt[fh[15:0]] != CNT_MAX) cnt[fh[15:0]]++;
        dec = fh;
      end else if (alloc) dec = grab_slot();
      if (zero) void'(ready_push(t, dec));
      else if (pv[pid]) begin
        ch = grab_slot(); cid = ch[15:0];
        pv[cid] = 1; ptag[cid] = t; pfin[cid] = dec;
        link[cid] = link[pid]; link[pid] = ch;
      end else begin
        pv[pid] = 1; ptag[pid] = t; pfin[pid] = dec;
      end
      resp = dec;
      return ST_OK;
    endfunction

    function logic [1:0] trigger_counter(logic [31:0] h, output bit rel);
      logic [31:0] it;
      int unsigned s;
      logic [1:0] st;
      rel = 0; st = ST_OK;
      if (!is_live(h)) return ST_OK;
      cnt[h[15:0]]--;
      if (cnt[h[15:0]] != 0) return ST_OK;
      it = h;
      for (int n = 0; n < SLOT_COUNT && pooled(it); n++) begin
        s = it[15:0];
        if (pv[s]) begin
          if (ready_push(ptag[s], pfin[s])) rel = 1; else st = ST_RDY_FULL;
          pv[s] = 0;
        end
        gen[s] = gen[s] + 16'd1; cnt[s] = 0;
        if (ftop < SLOT_COUNT) begin fstk[ftop] = s; ftop++; end
        it = link[s]; link[s] = NO_HANDLE;
      end
      return st;
    endfunction

    // Note an accepted request and queue what it must produce.
    function void note_request(logic [1:0] rq, logic [31:0] t, logic [31:0] pre, bit want,
                               logic [31:0] fh, logic [31:0] tgt);
      logic [1:0] st; logic [31:0] resp, ot, of; bit z, rel;
      st = ST_OK; resp = NO_HANDLE; ot = 0; of = NO_HANDLE; z = 0; rel = 0;
      case (rq)
        REQ_RUN:     st = run_job(t, pre, want, fh, resp);
        REQ_TRIGGER: st = trigger_counter(tgt, rel);
        REQ_TAKE: begin
          if (rtop == 0) st = ST_RDY_EMPT;
          else begin rtop--; ot = rtag[rtop]; of = rfin[rtop]; end
        end
        default:     z = !is_live(tgt);
      endcase
      q_st.push_back(st); q_resp.push_back(resp); q_tag.push_back(ot);
      q_fin.push_back(of); q_z.push_back(z); q_rel.push_back(rel);
    endfunction

    function void report(string f, logic [31:0] e, logic [31:0] a);
      $display("%0t mismatch %s: expected %h actual %h", $realtime, f, e, a);
      errors++;
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] resp, logic [31:0] ot,
                               logic [31:0] of, bit z, bit rel);
      if (q_st.size() == 0) begin
        $display("%0t unexpected result: expected none actual status %h", $realtime, st);
        errors++;
        return;
      end
      if (q_st[0] !== st) report("status", q_st[0], st);
      if (q_resp[0] !== resp) report("resp_handle", q_resp[0], resp);
      if (q_tag[0] !== ot) report("job_tag", q_tag[0], ot);
      if (q_fin[0] !== of) report("job_finish", q_fin[0], of);
      if (q_z[0] !== z) report("is_zero", q_z[0], z);
      if (q_rel[0] !== rel) report("released_any", q_rel[0], rel);
      void'(q_st.pop_front()); void'(q_resp.pop_front()); void'(q_tag.pop_front());
      void'(q_fin.pop_front()); void'(q_z.pop_front()); void'(q_rel.pop_front());
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [1:0]  in_req_type;
  logic [31:0] in_job_tag, in_precondition_handle, in_finish_handle, in_target_handle;
  logic        in_want_finish;
  logic        out_valid, out_is_zero, out_released_any;
  logic [1:0]  out_status;
  logic [31:0] out_resp_handle, out_out_job_tag, out_out_job_finish;

  dep_table_scoreboard sb;
  int  idle_cycles;
  bit  allow_gaps;

  job_dependency_counter_table_top dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog: count cycles with no request and no result accepted.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample results at the rising edge; the receiver never stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_resp_handle, out_out_job_tag, out_out_job_finish,
                      out_is_zero, out_released_any);
  end

  // Hold one request until accepted; start stays high until a gap or drain_results drops it.
  task automatic send_request(logic [1:0] rq, logic [31:0] t, logic [31:0] pre, bit want,
                              logic [31:0] fh, logic [31:0] tgt);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1; in_req_type <= rq; in_job_tag <= t; in_precondition_handle <= pre;
    in_want_finish <= want; in_finish_handle <= fh; in_target_handle <= tgt;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rq, t, pre, want, fh, tgt);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 0;
    while (sb.q_st.size() != 0) @(negedge clk);
  endtask

  // Pick a handle: mostly ones handed out, sometimes stale, bogus or none.
  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(0, 9);
    if (sb.live_handles.size() != 0 && r < 7)
      return sb.live_handles[$urandom_range(0, sb.live_handles.size() - 1)];
    if (r == 7) return NO_HANDLE;
    if (r == 8) return $urandom();
    return {16'($urandom_range(0, 2)), 16'($urandom_range(0, SLOT_COUNT - 1))};
  endfunction

  task automatic random_request();
    int r;
    logic [1:0] rq;
    r = $urandom_range(0, 99);
    rq = r < 40 ? REQ_RUN : r < 70 ? REQ_TRIGGER : r < 88 ? REQ_TAKE : REQ_QUERY;
    send_request(rq, $urandom(), pick_handle(), $urandom_range(0, 1),
                 $urandom_range(0, 3) == 0 ? NO_HANDLE : pick_handle(), pick_handle());
    // keep the handle list short so live ones dominate
    if (sb.live_handles.size() > 64) void'(sb.live_handles.pop_front());
  endtask

  initial begin
    logic [31:0] h0;
    sb = new();
    idle_cycles = 0; allow_gaps = 0;
    rst_n = 0; start = 0; in_req_type = REQ_RUN; in_job_tag = 0;
    in_precondition_handle = NO_HANDLE; in_want_finish = 0;
    in_finish_handle = NO_HANDLE; in_target_handle = NO_HANDLE;
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: empty take, invalid queries, then a chain of waiters released.
    send_request(REQ_TAKE, 0, NO_HANDLE, 0, NO_HANDLE, NO_HANDLE);
    send_request(REQ_QUERY, 0, NO_HANDLE, 0, NO_HANDLE, NO_HANDLE);
    send_request(REQ_QUERY, 0, NO_HANDLE, 0, NO_HANDLE, 32'h0000_FFFF);
    send_request(REQ_TRIGGER, 0, NO_HANDLE, 0, NO_HANDLE, 32'h0000_2000);
    send_request(REQ_RUN, 32'hFFFF_FFFF, NO_HANDLE, 1, NO_HANDLE, 0);
    h0 = sb.live_handles[0];
    send_request(REQ_QUERY, 0, NO_HANDLE, 0, NO_HANDLE, h0);
    // precondition equal to the slot being allocated
    send_request(REQ_RUN, 32'h1, {16'h0, 16'(SLOT_COUNT - 2)}, 1, NO_HANDLE, 0);
    send_request(REQ_RUN, 32'h2, h0, 1, NO_HANDLE, 0);
    send_request(REQ_RUN, 32'h3, h0, 0, NO_HANDLE, 0);
    send_request(REQ_RUN, 32'h4, h0, 1, h0, 0);
    send_request(REQ_RUN, 32'h5, 32'h0001_0000 | h0, 1, h0, 0);  // stale precondition
    send_request(REQ_TRIGGER, 0, NO_HANDLE, 0, NO_HANDLE, h0);
    send_request(REQ_TRIGGER, 0, NO_HANDLE, 0, NO_HANDLE, h0);
    send_request(REQ_TRIGGER, 0, NO_HANDLE, 0, NO_HANDLE, h0);   // releases the chain; h0 is stale after this
    send_request(REQ_QUERY, 0, NO_HANDLE, 0, NO_HANDLE, h0);
    repeat (4) send_request(REQ_TAKE, 0, NO_HANDLE, 0, NO_HANDLE, 0);
    drain_results();

    // Fill the ready store to hit the full cases, then empty it again.
    repeat (READY_DEPTH + 2) send_request(REQ_RUN, $urandom(), NO_HANDLE, 0, NO_HANDLE, 0);
    repeat (READY_DEPTH + 2) send_request(REQ_TAKE, 0, NO_HANDLE, 0, NO_HANDLE, 0);
    drain_results();

    // Random traffic with gaps, one full pause, then a gap-free tail.
    allow_gaps = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      if (i == N_RANDOM - 150) allow_gaps = 0;
      random_request();
    end
    drain_results();
    repeat (WD_LIMIT / 400) @(negedge clk);
    if (sb.errors == 0 && sb.q_st.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

`default_nettype wire

[files.f]
rtl/jdct_pkg.sv
rtl/jdct_free_stack.sv
rtl/job_dependency_counter_table_top.sv
tb/testbench.sv
